### hw/rtl/sensor_reply_crc_check_decode_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the sensor reply decoder modules
// ---------------------------------------------------------------------------
`ifndef SENSOR_REPLY_CRC_CHECK_DECODE_TOP_ASSERT_SVH
`define SENSOR_REPLY_CRC_CHECK_DECODE_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define SRCD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high
`define SRCD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset
`define SRCD_ASSERT_NXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/srcd_pkg.sv
// ---------------------------------------------------------------------------
// srcd_pkg
// Types, constants and the bytewise CRC-16 update for the sensor reply decoder.
// ---------------------------------------------------------------------------
package srcd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions within the eight-byte reply
  localparam logic [2:0] IDX_FIRST   = 3'd0;
  localparam logic [2:0] IDX_HUM_HI  = 3'd2;
  localparam logic [2:0] IDX_HUM_LO  = 3'd3;
  localparam logic [2:0] IDX_TEMP_HI = 3'd4;
  localparam logic [2:0] IDX_TEMP_LO = 3'd5;
  localparam logic [2:0] IDX_CRC_LO  = 3'd6;
  localparam logic [2:0] IDX_CRC_HI  = 3'd7;
  localparam logic [2:0] DATA_BYTES  = 3'd6;

  // Decoded reply, one per frame
  typedef struct packed {
    logic        emit;
    logic [15:0] humidity_tenths;
    logic [14:0] temperature_tenths;
    logic        crc_ok;
  } srcd_result_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/srcd_frame.sv
// ---------------------------------------------------------------------------
// srcd_frame
// Frame tracker: byte count, running CRC and field capture; decodes the
// result combinationally when the last reply byte is presented.
// ---------------------------------------------------------------------------
`include "sensor_reply_crc_check_decode_top_assert.svh"

module srcd_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  output srcd_pkg::srcd_result_t result
);
  import srcd_pkg::*;

  logic [2:0]  byte_count;
  logic [15:0] crc_running;
  logic [15:0] humidity_hold;
  logic [14:0] temperature_hold;
  logic [7:0]  crc_low_hold;

  logic [2:0]  idx;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic        crc_match;

  // Pick byte position and CRC seed; frame start forces a fresh reply
  assign idx      = frame_start ? IDX_FIRST : byte_count;
  assign crc_base = (idx == IDX_FIRST) ? CRC_INIT : crc_running;
  assign crc_match = ({rx_byte, crc_low_hold} == crc_base);

  always_comb begin
    if (idx < DATA_BYTES) begin
      crc_next = crc_update(crc_base, rx_byte);
    end else if (idx == IDX_CRC_HI) begin
      crc_next = CRC_INIT;
    end else begin
      crc_next = crc_base;
    end
  end

  // Build the result; zero the fields on a CRC mismatch
  always_comb begin
    result.emit               = (idx == IDX_CRC_HI);
    result.crc_ok             = crc_match;
    result.humidity_tenths    = crc_match ? humidity_hold : 16'h0000;
    result.temperature_tenths = crc_match ? temperature_hold : 15'h0000;
  end

  // Advance count and CRC, capture fields
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= IDX_FIRST;
      crc_running      <= CRC_INIT;
      humidity_hold    <= 16'h0000;
      temperature_hold <= 15'h0000;
      crc_low_hold     <= 8'h00;
    end else if (take) begin
      byte_count  <= idx + 3'd1;
      crc_running <= crc_next;
      case (idx)
        IDX_HUM_HI:  humidity_hold[15:8]    <= rx_byte;
        IDX_HUM_LO:  humidity_hold[7:0]     <= rx_byte;
        IDX_TEMP_HI: temperature_hold[14:8] <= rx_byte[6:0];
        IDX_TEMP_LO: temperature_hold[7:0]  <= rx_byte;
        IDX_CRC_LO:  crc_low_hold           <= rx_byte;
        default: ;
      endcase
    end
  end

  `SRCD_ASSERT_NXT(a_wrap_after_last, clk, rst, take && result.emit, byte_count == IDX_FIRST && crc_running == CRC_INIT, "count or CRC not restarted after last byte")
  `SRCD_ASSERT_NXT(a_start_counts_one, clk, rst, take && frame_start, byte_count == 3'd1, "frame start did not restart the count")

endmodule

### hw/rtl/srcd_out_reg.sv
// ---------------------------------------------------------------------------
// srcd_out_reg
// Result register with valid/ready handshake toward the receiver.
// ---------------------------------------------------------------------------
module srcd_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  srcd_pkg::srcd_result_t result,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            humidity_tenths,
  output logic [14:0]            temperature_tenths,
  output logic                   crc_ok
);
  import srcd_pkg::*;

  // Room for a new word when empty or when the held word leaves now
  assign free = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      humidity_tenths    <= result.humidity_tenths;
      temperature_tenths <= result.temperature_tenths;
      crc_ok             <= result.crc_ok;
    end
  end

endmodule

### hw/rtl/sensor_reply_crc_check_decode_top.sv
// ---------------------------------------------------------------------------
// sensor_reply_crc_check_decode_top
// Sensor reply decoder: CRC-16 check and humidity/temperature extraction.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one reply byte per word on rx_byte;
// frame_start marks byte 0 and restarts the count and CRC. Without it the
// count runs 0..7 and wraps, so the next byte opens a new reply.
// Output channel (out_valid/out_ready): one word per eight-byte reply, with
// humidity_tenths, temperature_tenths and crc_ok; on a CRC mismatch both
// value fields read zero.
// Path: an accepted byte waits in the input register; when the last reply
// byte moves on, its result loads into the result register.
// Throughput: one byte per cycle while no finished result is held up at the
// output; the CRC byte update between the input register and the frame
// state is combinational.
// Stall: a waiting result holds the input register only when the next byte
// there also completes a reply; other bytes keep flowing.
// Reset: empties both registers (clears their valid flags), restarts the
// count and seeds the CRC with all ones.
// ---------------------------------------------------------------------------
`include "sensor_reply_crc_check_decode_top_assert.svh"

module sensor_reply_crc_check_decode_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] humidity_tenths,
  output logic [14:0] temperature_tenths,
  output logic        crc_ok
);
  import srcd_pkg::*;

  logic         pipe_valid;
  logic [7:0]   pipe_byte;
  logic         pipe_start;
  logic         advance;
  logic         out_free;
  srcd_result_t result;

  // Move the held byte on unless its result cannot be stored
  assign advance  = pipe_valid && (!result.emit || out_free);
  assign in_ready = !pipe_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_ready) begin
      pipe_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pipe_byte  <= rx_byte;
      pipe_start <= frame_start;
    end
  end

  srcd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .take        (advance),
    .rx_byte     (pipe_byte),
    .frame_start (pipe_start),
    .result      (result)
  );

  srcd_out_reg u_out (
    .clk                (clk),
    .rst                (rst),
    .load               (advance && result.emit),
    .result             (result),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .humidity_tenths    (humidity_tenths),
    .temperature_tenths (temperature_tenths),
    .crc_ok             (crc_ok)
  );

  `SRCD_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !pipe_valid, "registers not empty after reset")
  `SRCD_ASSERT_IMP(a_bad_crc_zero, clk, rst, out_valid && !crc_ok, humidity_tenths == 16'h0000 && temperature_tenths == 15'h0000, "nonzero fields on CRC mismatch")
  `SRCD_ASSERT_NXT(a_pipe_hold, clk, rst, pipe_valid && !advance, pipe_valid && $stable(pipe_byte) && $stable(pipe_start), "stalled input register lost its byte")
  `SRCD_ASSERT_IMP(a_stall_only_on_emit, clk, rst, pipe_valid && !advance, result.emit && out_valid && !out_ready, "input register stalled without a blocked result")

endmodule

### tb/sv/tb_sensor_reply_crc_check_decode_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sensor_reply_crc_check_decode_top
// Self-checking bench for the sensor reply CRC check and decode block. A queue
// of reply bytes feeds a clocked driver with random gaps. Each accepted word
// runs through a local decoder model that keeps its own byte index, CRC and
// held fields. A clocked monitor with random back-pressure compares every
// decoded reply with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_sensor_reply_crc_check_decode_top;
  import srcd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_word_t;

  typedef struct packed {
    logic [15:0] humidity;
    logic [14:0] temperature;
    logic        ok;
  } reply_t;

  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] humidity_tenths;
  logic [14:0] temperature_tenths;
  logic        crc_ok;

  // Stimulus and prediction stores
  rx_word_t    byte_queue[$];
  reply_t      reply_q[$];

  // Model state of the decoder
  logic [2:0]  model_index = IDX_FIRST;
  logic [15:0] model_crc = CRC_INIT;
  logic [15:0] model_humidity = '0;
  logic [14:0] model_temperature = '0;
  logic [7:0]  model_crc_low = '0;

  // Byte index the generator expects the block to be at
  logic [2:0]  gen_index = IDX_FIRST;

  int unsigned stim_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned replies_seen = 0;
  int unsigned replies_good = 0;
  int unsigned fail_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_quiet = 0;
  int unsigned stall_left = 0;
  int unsigned stall_quiet = 0;

  sensor_reply_crc_check_decode_top uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_start       (frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .humidity_tenths   (humidity_tenths),
    .temperature_tenths(temperature_tenths),
    .crc_ok            (crc_ok)
  );

  always #1 clk = ~clk;

  // Reflected CRC-16 over one byte, shifting out the LSB each step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        lsb;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      lsb = c[0];
      c = {1'b0, c[15:1]};
      if (lsb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a quiet stretch
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet = quiet - 1;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(30, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Queue one word and track where the block will be in its reply
  function automatic void push_word(input logic [7:0] b, input logic fs);
    rx_word_t w;
    w.data = b;
    w.start = fs;
    byte_queue.push_back(w);
    gen_index = (fs ? IDX_FIRST : gen_index) + 3'd1;
  endfunction

  // Queue a full reply; flip corrupts the CRC bytes when nonzero
  function automatic void push_reply(input logic [47:0] body, input logic fs,
                                     input logic [15:0] flip);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      b = body[47 - 8 * k -: 8];
      crc = crc16_byte(crc, b);
      push_word(b, (k == 0) ? fs : 1'b0);
    end
    crc = crc ^ flip;
    push_word(crc[7:0], 1'b0);
    push_word(crc[15:8], 1'b0);
  endfunction

  // Advance the decoder model by one accepted word
  function automatic void predict_reply_byte(input logic [7:0] b, input logic fs);
    logic [2:0]  idx;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    reply_t      r;
    idx = fs ? IDX_FIRST : model_index;
    crc = (idx == IDX_FIRST) ? CRC_INIT : model_crc;
    if (idx < DATA_BYTES) begin
      crc = crc16_byte(crc, b);
    end
    case (idx)
      IDX_HUM_HI: begin
        model_humidity[15:8] = b;
      end
      IDX_HUM_LO: begin
        model_humidity[7:0] = b;
      end
      IDX_TEMP_HI: begin
        model_temperature[14:8] = b[6:0];
      end
      IDX_TEMP_LO: begin
        model_temperature[7:0] = b;
      end
      IDX_CRC_LO: begin
        model_crc_low = b;
      end
      IDX_CRC_HI: begin
        rx_crc = {b, model_crc_low};
        r.ok = (rx_crc == crc);
        r.humidity = r.ok ? model_humidity : 16'h0000;
        r.temperature = r.ok ? model_temperature : 15'h0000;
        reply_q.push_back(r);
        crc = CRC_INIT;
      end
      default: begin
      end
    endcase
    model_crc = crc;
    model_index = idx + 3'd1;
  endfunction

  // Driver: present queued words, hold until accepted, then idle a while
  always @(posedge clk) begin
    rx_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reply_byte(rx_byte, frame_start);
        bytes_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the word
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        w = byte_queue.pop_front();
        in_valid <= 1'b1;
        rx_byte <= w.data;
        frame_start <= w.start;
        send_gap = pick_gap(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each decoded word against the oldest prediction, stall at random
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: unexpected reply hum=%h temp=%h ok=%b", $realtime,
                     humidity_tenths, temperature_tenths, crc_ok);
          end
        end else begin
          exp_r = reply_q.pop_front();
          if (exp_r.ok) replies_good++;
          if (humidity_tenths !== exp_r.humidity || temperature_tenths !== exp_r.temperature ||
              crc_ok !== exp_r.ok) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: reply mismatch exp hum=%h temp=%h ok=%b got hum=%h temp=%h ok=%b",
                       $realtime, exp_r.humidity, exp_r.temperature, exp_r.ok,
                       humidity_tenths, temperature_tenths, crc_ok);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(stall_quiet);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [47:0] body;
    logic        fs;
    logic [15:0] flip;
    int unsigned pick;
    int unsigned n;
    int unsigned r;

    // Extreme fields, top bit of the temperature high byte set (dropped by the decoder), good CRC
    push_reply({8'h03, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 16'h0000);
    // Drop a partial reply by restarting mid-frame; all-zero body with a bad CRC
    push_word(8'h03, 1'b1);
    push_word(8'h04, 1'b0);
    push_reply(48'h0, 1'b1, 16'h0001);
    // Start a reply by wrapping the count, no frame start
    push_reply({8'h03, 8'h04, 8'h02, 8'h5A, 8'h80, 8'hA5}, 1'b0, 16'h0000);

    // Random phase: mostly full replies, some broken replies and noise
    while (byte_queue.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        for (int k = 0; k < 6; k++) begin
          r = $urandom_range(0, 7);
          body[47 - 8 * k -: 8] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        end
        fs = (gen_index == IDX_FIRST) ? 1'($urandom_range(0, 1)) : 1'b1;
        flip = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        push_reply(body, fs, flip);
      end else if (pick < 90) begin
        n = $urandom_range(1, 7);
        for (int k = 0; k < n; k++) begin
          push_word(8'($urandom), k == 0);
        end
      end else begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          push_word(8'($urandom), $urandom_range(0, 3) == 0);
        end
      end
    end
    stim_total = byte_queue.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != stim_total || reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d reply bytes and %0d decoded replies (%0d good CRC, %0d rejected)",
             bytes_taken, replies_seen, replies_good, replies_seen - replies_good);
    if (fail_count == 0) begin
      $display("sensor_reply_crc_check_decode_top regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("sensor_reply_crc_check_decode_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout: %0d of %0d bytes taken, %0d replies pending",
             bytes_taken, stim_total, reply_q.size());
    $display("sensor_reply_crc_check_decode_top regression: fail");
    $finish;
  end

endmodule

### sensor_reply_crc_check_decode_top.f
+incdir+hw/rtl
hw/rtl/srcd_pkg.sv
hw/rtl/srcd_frame.sv
hw/rtl/srcd_out_reg.sv
hw/rtl/sensor_reply_crc_check_decode_top.sv
tb/sv/tb_sensor_reply_crc_check_decode_top.sv
